FILE: design/irmd_pkg.sv
package irmd_pkg;

    localparam int DEF_WIN_DEPTH = 30;

    localparam logic [3:0] TOP_BIT        = 4'd13;
    localparam logic [3:0] START_MIN_CODE = 4'd9;
    localparam logic [3:0] SHORT_LOW_CODE = 4'd1;
    localparam logic [3:0] PAIR_LIMIT     = 4'd4;
    localparam logic [3:0] LONG_CODE      = 4'd2;
    localparam logic [3:0] LOW_CODE       = 4'd1;
    localparam logic [3:0] INVALID_CODE   = 4'd10;

    localparam logic [1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [1:0] CFG_LONG_MIN  = 2'd1;
    localparam logic [1:0] CFG_MAX_VALID = 2'd2;

    localparam logic [15:0] RST_SHORT_MIN = 16'd444;
    localparam logic [15:0] RST_LONG_MIN  = 16'd1333;
    localparam logic [15:0] RST_MAX_VALID = 16'd2222;

    typedef struct packed {
        logic write;
        logic scan_init;
        logic scan_step;
        logic shift;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last_pos;
        logic need_shift;
    } status_t;

endpackage

FILE: design/irmd_ctrl.sv
module irmd_ctrl
    import irmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output cmd_t    cmd,
    input  status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.write     = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.last_pos)
                begin
                    state_next = status.need_shift ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/irmd_datapath.sv
module irmd_datapath
    import irmd_pkg::*;
#(
    parameter int WIN_DEPTH = DEF_WIN_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [15:0] interval_ticks,
    input  logic        pin_level,
    output logic [13:0] decoded_word
);

    localparam int IDX_W = $clog2(WIN_DEPTH);

    logic [3:0]       win_reg [WIN_DEPTH];
    logic [IDX_W-1:0] wi_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [3:0]       bitpos_reg;
    logic [13:0]      word_reg;
    logic [13:0]      out_word_reg;
    logic             start_reg;
    logic             skip_reg;
    logic [15:0]      short_min_reg;
    logic [15:0]      long_min_reg;
    logic [15:0]      max_valid_reg;

    logic [3:0] code;
    logic [3:0] head_a;
    logic [3:0] head_b;
    logic       pair_ok;
    logic       pos_in_range;

    always_comb
    begin
        code = '0;
        if (interval_ticks > long_min_reg)
        begin
            code = LONG_CODE;
        end
        if (!pin_level)
        begin
            code = code + LOW_CODE;
        end
        if ((interval_ticks < short_min_reg) || (interval_ticks > max_valid_reg))
        begin
            code = code + INVALID_CODE;
        end
    end

    assign head_a       = win_reg[0];
    assign head_b       = win_reg[1];
    assign pair_ok      = (head_a < PAIR_LIMIT) && (head_b < PAIR_LIMIT);
    assign pos_in_range = (pos_reg >= IDX_W'(2)) && (pos_reg <= IDX_W'(WIN_DEPTH - 2));

    assign status.last_pos   = (pos_reg == IDX_W'(WIN_DEPTH - 1));
    assign status.need_shift = (wi_reg == IDX_W'(WIN_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg <= RST_SHORT_MIN;
            long_min_reg  <= RST_LONG_MIN;
            max_valid_reg <= RST_MAX_VALID;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SHORT_MIN: short_min_reg <= cfg_data;
                CFG_LONG_MIN:  long_min_reg  <= cfg_data;
                CFG_MAX_VALID: max_valid_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The scan rotates the window one entry a cycle, so the pair under
    // examination always sits in the two lowest entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            wi_reg <= '0;
        end
        else if (cmd.write)
        begin
            win_reg[wi_reg] <= code;
            wi_reg          <= wi_reg + IDX_W'(1);
        end
        else if (cmd.scan_step)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_DEPTH-1] <= win_reg[0];
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            wi_reg <= wi_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            bitpos_reg <= TOP_BIT;
            word_reg   <= '0;
            start_reg  <= 1'b0;
            skip_reg   <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            pos_reg    <= '0;
            bitpos_reg <= TOP_BIT;
            word_reg   <= '0;
            start_reg  <= 1'b0;
            skip_reg   <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            pos_reg <= pos_reg + IDX_W'(1);
            if (pos_reg == '0)
            begin
                start_reg <= (head_a > START_MIN_CODE) && (head_b == SHORT_LOW_CODE);
            end
            if (start_reg && pos_in_range)
            begin
                if (skip_reg)
                begin
                    skip_reg <= 1'b0;
                end
                else if (pair_ok)
                begin
                    if (!head_a[0] && head_b[0])
                    begin
                        word_reg <= word_reg | (14'd1 << bitpos_reg);
                    end
                    if (bitpos_reg != '0)
                    begin
                        bitpos_reg <= bitpos_reg - 4'd1;
                    end
                    skip_reg <= (head_b <= SHORT_LOW_CODE);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word_reg <= start_reg ? word_reg : '0;
        end
    end

    assign decoded_word = out_word_reg;

    a_wi_range: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= IDX_W'(WIN_DEPTH - 1))
        else $error("write index beyond window");

    a_shift_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |=> (wi_reg == IDX_W'(WIN_DEPTH - 2)))
        else $error("shift left write index off");

    a_bitpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bitpos_reg <= TOP_BIT)
        else $error("bit position beyond top bit");

    a_no_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !start_reg) |=> (out_word_reg == '0))
        else $error("nonzero word without start");

endmodule

FILE: design/ir_manchester_pulse_decoder_core.sv
// Sequence: an accepted item is written into the pulse window, then the window is rescanned
// by rotation, one entry per cycle, then shifted down by one entry when the write index has
// reached the last entry, and the result is loaded into the output register once the output is free.
// The core takes no new item until that result is loaded; in_stall stays high meanwhile.
// Reset: thresholds return to 444, 1333 and 2222, the window and write index clear,
// and no result is pending.
module ir_manchester_pulse_decoder_core
    import irmd_pkg::*;
#(
    parameter int WIN_DEPTH = DEF_WIN_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] interval_ticks,
    input  logic        pin_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] decoded_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    irmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    irmd_datapath #(
        .WIN_DEPTH (WIN_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .interval_ticks (interval_ticks),
        .pin_level      (pin_level),
        .decoded_word   (decoded_word)
    );

endmodule
